### rtl/tcc_pkg.sv
// tcc_pkg: shared types, codes and constants of the tone command controller
// no dependencies
package tcc_pkg;

  localparam int unsigned LineLength = 32;
  localparam int unsigned LcW = 6;
  localparam logic [13:0] NumSat = 14'd16383;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_LOCK   = 2'd2;
  localparam logic [1:0] KIND_AOFF   = 2'd3;

  localparam logic [1:0] OK_BYTE   = 2'd0;
  localparam logic [1:0] OK_RESP   = 2'd1;
  localparam logic [1:0] OK_STATUS = 2'd2;

  localparam logic [1:0] RC_OK   = 2'd0;
  localparam logic [1:0] RC_INV  = 2'd1;
  localparam logic [1:0] RC_UNK  = 2'd2;
  localparam logic [1:0] RC_IDN  = 2'd3;

  localparam logic [2:0] PH_KEY    = 3'd0;
  localparam logic [2:0] PH_SPACE  = 3'd1;
  localparam logic [2:0] PH_PLUS   = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;
  localparam logic [2:0] PH_FAIL   = 3'd5;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_STEP = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [2:0] button;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [1:0]  response_code;
    logic        tone_enable;
    logic [15:0] tone_prescaler;
    logic [3:0]  button_mask;
    logic [2:0]  selected_button;
    logic        start_lockout;
    logic        start_auto_off;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_beat_t;

  // controller to datapath commands
  typedef struct packed {
    logic       exec;      // apply the item (parse, buttons, timers)
    logic       div_start; // start the divider
    logic       div_step;  // one divider iteration
    logic       div_done;  // write divider result
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       need_div;  // item asks for a new frequency
    logic       div_last;  // final divider iteration
    logic       line_end;  // three beats to send
  } dp_sts_t;

  function automatic logic [7:0] kw_idn(input logic [2:0] p);
    unique case (p)
      3'd0: kw_idn = 8'h2A;
      3'd1: kw_idn = 8'h49;
      3'd2: kw_idn = 8'h44;
      3'd3: kw_idn = 8'h4E;
      3'd4: kw_idn = 8'h3F;
      default: kw_idn = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_off(input logic [2:0] p);
    unique case (p)
      3'd0: kw_off = 8'h46;
      3'd1: kw_off = 8'h52;
      3'd2: kw_off = 8'h45;
      3'd3: kw_off = 8'h51;
      3'd4: kw_off = 8'h20;
      3'd5: kw_off = 8'h4F;
      3'd6: kw_off = 8'h46;
      default: kw_off = 8'h46;
    endcase
  endfunction

  function automatic logic [7:0] kw_tone(input logic [1:0] p);
    unique case (p)
      2'd0: kw_tone = 8'h54;
      2'd1: kw_tone = 8'h4F;
      2'd2: kw_tone = 8'h4E;
      default: kw_tone = 8'h45;
    endcase
  endfunction

endpackage

### rtl/tcc_if.sv
// tcc_if: valid/ready channel interfaces for items, results and register writes
// depends on tcc_pkg
interface tcc_in_if;
  logic valid;
  logic ready;
  tcc_pkg::in_beat_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface tcc_out_if;
  logic valid;
  logic ready;
  tcc_pkg::out_beat_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface tcc_cfg_if;
  logic valid;
  logic ready;
  tcc_pkg::cfg_beat_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

### rtl/tone_command_controller_top.sv
// tone_command_controller_top: serial/button tone controller, top level
// depends on tcc_pkg, tcc_if, tcc_ctrl, tcc_datapath
//
// channel  dir  payload
// in_ch    in   kind, rx_byte, button
// out_ch   out  out_kind .. last, one or three beats per item
// cfg_ch   in   index, data (0 base_rate, 1 tone_step)
//
// an item runs through execute and a status check, then one beat per result is sent;
// when a new frequency is set, the restoring divider runs before the beats go out
// one item at a time; in_ch ready only when the previous item is fully sent
// reset clears parser, buttons and registers to their defaults at once
// stalls on out_ch hold the pending beat; cfg_ch is always ready
module tone_command_controller_top (
  input logic clk_i,
  input logic rst_ni,
  tcc_in_if.sink    in_ch,
  tcc_out_if.source out_ch,
  tcc_cfg_if.sink   cfg_ch
);
  import tcc_pkg::*;

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  out_beat_t res;
  logic      load;

  assign cfg_ch.ready = 1'b1;

  tcc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready), .load_o(load),
    .cmd_o(cmd), .sts_i(sts), .res_i(res),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .out_o(out_ch.payload)
  );

  tcc_datapath u_dp (
    .clk_i, .rst_ni,
    .item_i(in_ch.payload), .load_i(load),
    .cfg_i(cfg_ch.payload), .cfg_we_i(cfg_ch.valid),
    .cmd_i(cmd), .sts_o(sts), .res_o(res)
  );
endmodule

### rtl/tcc_datapath.sv
// tcc_datapath: line parser, button state, frequency multiply and serial divider
// depends on tcc_pkg
module tcc_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcc_pkg::in_beat_t  item_i,
  input  logic               load_i,
  input  tcc_pkg::cfg_beat_t cfg_i,
  input  logic               cfg_we_i,
  input  tcc_pkg::dp_cmd_t   cmd_i,
  output tcc_pkg::dp_sts_t   sts_o,
  output tcc_pkg::out_beat_t res_o
);
  import tcc_pkg::*;

  logic [15:0] base_q;
  logic [13:0] step_q;
  in_beat_t    it_q;
  logic [LcW-1:0] lc_q, lc_d;
  logic [3:0]  mf_q, mf_d;
  logic [13:0] num_q, num_d;
  logic [2:0]  ph_q, ph_d;
  logic [2:0]  sel_q, sel_d, prev_q, prev_d;
  logic [3:0]  pm_q, pm_d;
  logic        run_q, run_d;
  logic [15:0] divv_q;
  logic        nd_d, nd_q, end_d, end_q, lock_d, lock_q, aoff_d, aoff_q;
  logic [1:0]  code_d, code_q;
  logic [23:0] freq_d, freq_q;
  // divider
  logic [15:0] quo_q;
  logic [16:0] rem_q;
  logic [3:0]  dcnt_q;
  logic [24:0] trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 16'd36000;
      step_q <= 14'd1000;
    end else if (cfg_we_i) begin
      if (cfg_i.index == {1'b0, REG_BASE}) base_q <= cfg_i.data;
      else if (cfg_i.index == {1'b0, REG_STEP}) step_q <= cfg_i.data[13:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) it_q <= item_i;
  end

  logic [7:0] c;
  logic       dig, spc, full;
  logic [13:0] dv;
  logic [17:0] acc;
  logic [2:0]  bidx;
  logic        num_ok;
  assign c    = it_q.rx_byte;
  assign dig  = (c >= 8'h30) && (c <= 8'h39);
  assign spc  = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  assign full = lc_q >= LcW'(LineLength);
  assign dv   = {10'd0, c[3:0]};
  assign acc  = {num_q, 3'd0} + {3'd0, num_q, 1'b0} + {4'd0, dv};
  assign bidx = it_q.button - 3'd1;
  assign num_ok = (ph_q == PH_DIGITS) || (ph_q == PH_DONE);

  always_comb begin
    lc_d = lc_q; mf_d = mf_q; num_d = num_q; ph_d = ph_q;
    sel_d = sel_q; prev_d = prev_q; pm_d = pm_q; run_d = run_q;
    nd_d = 1'b0; end_d = 1'b0; lock_d = 1'b0; aoff_d = 1'b0;
    code_d = RC_OK; freq_d = '0;
    unique case (it_q.kind)
      KIND_BYTE: begin
        if (c == 8'h0D || full) begin
          end_d = 1'b1;
          if (mf_q[0] && lc_q >= LcW'(5)) code_d = RC_IDN;
          else if (mf_q[1] && lc_q >= LcW'(4)) begin
            if (num_ok && num_q >= 14'd1 && num_q <= 14'd4) begin
              freq_d = 24'(num_q[2:0]) * 24'(step_q);
              nd_d = 1'b1; pm_d = 4'h0; aoff_d = 1'b1;
            end else code_d = RC_INV;
          end else if (mf_q[2] && lc_q >= LcW'(4)) begin
            if (mf_q[3] && lc_q == LcW'(8)) begin
              run_d = 1'b0; pm_d = 4'hF;
            end else if (num_ok && num_q >= 14'd1 && num_q <= 14'd9999) begin
              freq_d = {10'd0, num_q}; nd_d = 1'b1; pm_d = 4'h0;
            end else code_d = RC_INV;
          end else code_d = RC_UNK;
          lc_d = '0; mf_d = 4'hF; num_d = '0; ph_d = PH_KEY;
        end else if (c != 8'h00) begin
          if (lc_q >= LcW'(5) || c != kw_idn(lc_q[2:0])) mf_d[0] = 1'b0;
          if (lc_q >= LcW'(8) || c != kw_off(lc_q[2:0])) mf_d[3] = 1'b0;
          if (lc_q < LcW'(4)) begin
            if (c != kw_tone(lc_q[1:0])) mf_d[1] = 1'b0;
            if (c != kw_off(lc_q[2:0])) mf_d[2] = 1'b0;
            if (lc_q == LcW'(3)) ph_d = PH_SPACE;
          end else if (ph_q == PH_SPACE) begin
            if (dig) begin num_d = dv; ph_d = PH_DIGITS; end
            else if (c == 8'h2B) ph_d = PH_PLUS;
            else if (!spc) ph_d = PH_FAIL;
          end else if (ph_q == PH_PLUS) begin
            if (dig) begin num_d = dv; ph_d = PH_DIGITS; end
            else ph_d = PH_FAIL;
          end else if (ph_q == PH_DIGITS) begin
            if (dig) num_d = (acc > {4'd0, NumSat}) ? NumSat : acc[13:0];
            else ph_d = PH_DONE;
          end
          lc_d = lc_q + LcW'(1);
        end
      end
      KIND_BUTTON: begin
        if (it_q.button >= 3'd1 && it_q.button <= 3'd4 && pm_q[bidx[1:0]]) begin
          pm_d[bidx[1:0]] = 1'b0;
          lock_d = 1'b1;
          if (sel_q == 3'd0) begin
            freq_d = 24'(it_q.button) * 24'(step_q);
            nd_d = 1'b1; sel_d = it_q.button; prev_d = it_q.button;
          end else if (sel_q == it_q.button) begin
            sel_d = 3'd0; prev_d = it_q.button; run_d = 1'b0;
          end
        end
      end
      KIND_LOCK: begin
        if (prev_q >= 3'd1 && prev_q <= 3'd4) pm_d[2'(prev_q - 3'd1)] = 1'b1;
      end
      default: begin
        run_d = 1'b0; pm_d = 4'hF;
      end
    endcase
    if (nd_d) run_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q <= '0; mf_q <= 4'hF; num_q <= '0; ph_q <= PH_KEY;
      sel_q <= '0; prev_q <= '0; pm_q <= 4'hF; run_q <= 1'b0;
      nd_q <= 1'b0; end_q <= 1'b0; lock_q <= 1'b0; aoff_q <= 1'b0;
      code_q <= RC_OK;
    end else if (cmd_i.exec) begin
      lc_q <= lc_d; mf_q <= mf_d; num_q <= num_d; ph_q <= ph_d;
      sel_q <= sel_d; prev_q <= prev_d; pm_q <= pm_d; run_q <= run_d;
      nd_q <= nd_d; end_q <= end_d; lock_q <= lock_d; aoff_q <= aoff_d;
      code_q <= code_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) freq_q <= freq_d;
  end

  // restoring divider, one quotient bit a cycle, msb first
  assign trial = {8'd0, rem_q[15:0], base_q[dcnt_q]} - {1'b0, freq_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divv_q <= '0; dcnt_q <= '0; rem_q <= '0; quo_q <= '0;
    end else begin
      if (cmd_i.div_start) begin
        dcnt_q <= 4'd15; rem_q <= '0; quo_q <= '0;
      end else if (cmd_i.div_step) begin
        if (!trial[24]) begin
          rem_q <= trial[16:0]; quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          rem_q <= {rem_q[15:0], base_q[dcnt_q]}; quo_q <= {quo_q[14:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 4'd1;
      end
      if (cmd_i.div_done)
        divv_q <= ((freq_q == '0) ? 16'hFFFF : quo_q) - 16'd1;
    end
  end

  assign sts_o.need_div = nd_q;
  assign sts_o.div_last = dcnt_q == 4'd0;
  assign sts_o.line_end = end_q;

  always_comb begin
    res_o = '0;
    res_o.tone_enable     = run_q;
    res_o.tone_prescaler  = divv_q;
    res_o.button_mask     = pm_q;
    res_o.selected_button = sel_q;
    res_o.last            = 1'b1;
    if (it_q.kind == KIND_BYTE) begin
      if (end_q) begin
        res_o.out_kind = OK_RESP;
        res_o.response_code = code_q;
        res_o.start_auto_off = aoff_q;
      end else begin
        res_o.out_byte = c;
      end
    end else begin
      res_o.out_kind = OK_STATUS;
      res_o.start_lockout = lock_q;
    end
  end

endmodule

### rtl/tcc_ctrl.sv
// tcc_ctrl: sequencer that runs one item through execute, divide when needed and send beats
// depends on tcc_pkg
module tcc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               load_o,
  output tcc_pkg::dp_cmd_t   cmd_o,
  input  tcc_pkg::dp_sts_t   sts_i,
  input  tcc_pkg::out_beat_t res_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcc_pkg::out_beat_t out_o
);
  import tcc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_DIVS = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_SEND = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] beat_q, beat_d;

  assign in_ready_o = state_q == S_IDLE;
  assign load_o = in_valid_i && in_ready_o;
  assign out_valid_o = state_q == S_SEND;

  always_comb begin
    state_d = state_q;
    beat_d = beat_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = S_DIVS;
      end
      S_DIVS: begin
        beat_d = sts_i.line_end ? 2'd0 : 2'd2;
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else state_d = S_SEND;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.div_done = 1'b1;
        state_d = S_SEND;
      end
      S_SEND: if (out_ready_i) begin
        if (beat_q == 2'd2) state_d = S_IDLE;
        else beat_d = beat_q + 2'd1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      beat_q <= 2'd0;
    end else begin
      state_q <= state_d;
      beat_q <= beat_d;
    end
  end

  // newline beats ahead of the response
  always_comb begin
    out_o = res_i;
    if (beat_q != 2'd2) begin
      out_o.out_kind = OK_BYTE;
      out_o.out_byte = (beat_q == 2'd0) ? 8'h0A : 8'h0D;
      out_o.response_code = RC_OK;
      out_o.start_auto_off = 1'b0;
      out_o.start_lockout = 1'b0;
      out_o.last = 1'b0;
    end
  end

  a_div_done_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_done |=> state_q == S_SEND) else $error("divider not followed by send");
  a_load_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o |=> state_q == S_EXEC) else $error("accepted item not executed");
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_o.last) |=> in_ready_o)
    else $error("block busy after final beat");
endmodule

### verif/tone_command_controller_top_test.sv
// tone_command_controller_top_test: self-checking bench for the tone command controller
// drives serial lines, buttons, timer expiries and register writes; predicts every beat
// depends on tcc_pkg, tcc_if and tone_command_controller_top
module tone_command_controller_top_test;
  import tcc_pkg::*;

  localparam int unsigned StallLimit = 4000;

  // behavioral copy of the controller plus a queue of beats still to come
  class tone_scoreboard;
    logic [15:0] base_rate;
    logic [13:0] tone_step;
    int unsigned line_cnt;
    logic [3:0]  match;
    logic [13:0] num;
    logic [2:0]  phase;
    logic [2:0]  sel_btn;
    logic [2:0]  prev_btn;
    logic [3:0]  mask;
    logic        running;
    logic [15:0] divider;
    out_beat_t   awaited[$];
    int unsigned errors;
    int unsigned beats;
    int unsigned lines;

    function void reset_state();
      base_rate = 16'd36000;
      tone_step = 14'd1000;
      clear_line();
      sel_btn = '0;
      prev_btn = '0;
      mask = 4'hF;
      running = 1'b0;
      divider = '0;
      errors = 0;
      beats = 0;
      lines = 0;
    endfunction

    function void clear_line();
      line_cnt = 0;
      match = 4'hF;
      num = '0;
      phase = PH_KEY;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      if (idx == 2'(REG_BASE)) base_rate = data;
      else if (idx == 2'(REG_STEP)) tone_step = data[13:0];
    endfunction

    function void set_freq(logic [23:0] f);
      logic [15:0] q;
      q = (f == 0) ? 16'hFFFF : 16'(base_rate / f);
      divider = q - 16'd1;
      running = 1'b1;
    endfunction

    function void feed(logic [7:0] c);
      string idn;
      string off;
      string tone;
      bit digit;
      int unsigned v;
      idn = "*IDN?";
      off = "FREQ OFF";
      tone = "TONE";
      digit = (c >= "0" && c <= "9");
      if (line_cnt >= 5 || c != idn[line_cnt]) match[0] = 1'b0;
      if (line_cnt >= 8 || c != off[line_cnt]) match[3] = 1'b0;
      if (line_cnt < 4) begin
        if (c != tone[line_cnt]) match[1] = 1'b0;
        if (c != off[line_cnt]) match[2] = 1'b0;
        if (line_cnt == 3) phase = PH_SPACE;
      end else if (phase == PH_SPACE) begin
        if (digit) begin
          num = 14'(c - "0");
          phase = PH_DIGITS;
        end else if (c == "+") begin
          phase = PH_PLUS;
        end else if (!(c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))) begin
          phase = PH_FAIL;
        end
      end else if (phase == PH_PLUS) begin
        if (digit) begin
          num = 14'(c - "0");
          phase = PH_DIGITS;
        end else begin
          phase = PH_FAIL;
        end
      end else if (phase == PH_DIGITS) begin
        if (digit) begin
          v = num * 10 + (c - "0");
          num = (v > NumSat) ? NumSat : 14'(v);
        end else begin
          phase = PH_DONE;
        end
      end
      line_cnt++;
    endfunction

    // executes a finished line, returns the response code
    function logic [1:0] run_line(output bit aoff);
      bit num_ok;
      num_ok = (phase == PH_DIGITS || phase == PH_DONE);
      aoff = 0;
      if (match[0] && line_cnt >= 5) return RC_IDN;
      if (match[1] && line_cnt >= 4) begin
        if (num_ok && num >= 1 && num <= 4) begin
          set_freq(24'(num) * 24'(tone_step));
          mask = 4'h0;
          aoff = 1;
          return RC_OK;
        end
        return RC_INV;
      end
      if (match[2] && line_cnt >= 4) begin
        if (match[3] && line_cnt == 8) begin
          running = 1'b0;
          mask = 4'hF;
          return RC_OK;
        end
        if (num_ok && num >= 1 && num <= 9999) begin
          set_freq(24'(num));
          mask = 4'h0;
          return RC_OK;
        end
        return RC_INV;
      end
      return RC_UNK;
    endfunction

    function out_beat_t beat(logic [1:0] ok, logic [7:0] b, logic [1:0] rc,
                             bit lock, bit aoff, bit fin);
      out_beat_t r;
      r.out_kind = ok;
      r.out_byte = b;
      r.response_code = rc;
      r.tone_enable = running;
      r.tone_prescaler = divider;
      r.button_mask = mask;
      r.selected_button = sel_btn;
      r.start_lockout = lock;
      r.start_auto_off = aoff;
      r.last = fin;
      return r;
    endfunction

    // note an accepted input beat and queue what it should produce
    function void note_item(in_beat_t it);
      bit aoff;
      bit lock;
      logic [1:0] rc;
      lock = 0;
      if (it.kind == KIND_BYTE) begin
        if (it.rx_byte == 8'h0D || line_cnt >= LineLength) begin
          rc = run_line(aoff);
          clear_line();
          lines++;
          awaited.push_back(beat(OK_BYTE, 8'h0A, RC_OK, 0, 0, 0));
          awaited.push_back(beat(OK_BYTE, 8'h0D, RC_OK, 0, 0, 0));
          awaited.push_back(beat(OK_RESP, 8'h00, rc, 0, aoff, 1));
          return;
        end
        if (it.rx_byte != 0) feed(it.rx_byte);
        awaited.push_back(beat(OK_BYTE, it.rx_byte, RC_OK, 0, 0, 1));
        return;
      end
      if (it.kind == KIND_BUTTON) begin
        if (it.button >= 1 && it.button <= 4 && mask[it.button - 1]) begin
          mask[it.button - 1] = 1'b0;
          lock = 1;
          if (sel_btn == 0) begin
            set_freq(24'(it.button) * 24'(tone_step));
            sel_btn = it.button;
            prev_btn = it.button;
          end else if (sel_btn == it.button) begin
            sel_btn = '0;
            prev_btn = it.button;
            running = 1'b0;
          end
        end
      end else if (it.kind == KIND_LOCK) begin
        if (prev_btn >= 1 && prev_btn <= 4) mask[prev_btn - 1] = 1'b1;
      end else begin
        running = 1'b0;
        mask = 4'hF;
      end
      awaited.push_back(beat(OK_STATUS, 8'h00, RC_OK, lock, 0, 1));
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch at %0t on beat %0d: %s got %0h want %0h", $time, beats, what,
               got, want);
      errors++;
    endtask

    // compare one output beat with the oldest expectation
    task check_beat(out_beat_t got);
      out_beat_t w;
      beats++;
      if (awaited.size() == 0) begin
        report("unexpected beat", got, 0);
        return;
      end
      w = awaited.pop_front();
      if (got.out_kind != w.out_kind) report("out_kind", got.out_kind, w.out_kind);
      if (got.out_byte != w.out_byte) report("out_byte", got.out_byte, w.out_byte);
      if (got.response_code != w.response_code)
        report("response_code", got.response_code, w.response_code);
      if (got.tone_enable != w.tone_enable)
        report("tone_enable", got.tone_enable, w.tone_enable);
      if (got.tone_prescaler != w.tone_prescaler)
        report("tone_prescaler", got.tone_prescaler, w.tone_prescaler);
      if (got.button_mask != w.button_mask)
        report("button_mask", got.button_mask, w.button_mask);
      if (got.selected_button != w.selected_button)
        report("selected_button", got.selected_button, w.selected_button);
      if (got.start_lockout != w.start_lockout)
        report("start_lockout", got.start_lockout, w.start_lockout);
      if (got.start_auto_off != w.start_auto_off)
        report("start_auto_off", got.start_auto_off, w.start_auto_off);
      if (got.last != w.last) report("last", got.last, w.last);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  tcc_in_if  in_ch();
  tcc_out_if out_ch();
  tcc_cfg_if cfg_ch();

  tone_command_controller_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  tone_scoreboard sb;
  bit             quiet;      // no idling on either side while set
  int unsigned    n_items;
  int unsigned    stall_cnt;

  // 10 unit clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // result side: random backpressure except in the quiet stretch
  always @(posedge clk_i) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= 8);
  end

  // every accepted result beat goes straight to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_beat(out_ch.payload);
  end

  // watchdog on cycles where no channel moves a beat
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("timeout: no beat for %0d cycles", StallLimit);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // one input beat, with an occasional gap in front
  task automatic send_item(in_beat_t it);
    if (!quiet && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_item(it);
    n_items++;
  endtask

  task automatic send_byte(logic [7:0] c);
    in_beat_t it;
    it.kind = KIND_BYTE;
    it.rx_byte = c;
    it.button = 3'($urandom);
    send_item(it);
  endtask

  task automatic send_event(logic [1:0] k, logic [2:0] b);
    in_beat_t it;
    it.kind = k;
    it.rx_byte = 8'($urandom);
    it.button = b;
    send_item(it);
  endtask

  task automatic send_line(string s);
    foreach (s[i]) send_byte(s[i]);
    send_byte(8'h0D);
  endtask

  // stop sending and let every expected beat arrive
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.awaited.size() != 0);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= '{index: idx, data: data};
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.set_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // one command line with random shape; sometimes overlong and ended by the limit
  task automatic random_line();
    string kws[8];
    string kw;
    logic [7:0] seps[5];
    int unsigned ndig;
    int unsigned len;
    kws = '{"*IDN?", "TONE", "FREQ", "FREQ OFF", "TON", "*IDN", "XQZW", "tone"};
    seps = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C};
    kw = kws[$urandom_range(7)];
    len = 0;
    foreach (kw[i]) begin
      send_byte(kw[i]);
      len++;
    end
    if (kw != "FREQ OFF" || $urandom_range(3) == 0) begin
      repeat ($urandom_range(0, 2)) begin
        send_byte(seps[$urandom_range(4)]);
        len++;
      end
      case ($urandom_range(7))
        0: begin send_byte("+"); len++; end
        1: begin send_byte("-"); len++; end
        2: begin send_byte("x"); len++; end
        default: ;
      endcase
      // short numbers mostly, long ones to reach saturation
      ndig = ($urandom_range(5) == 0) ? $urandom_range(0, 7) : 1;
      repeat (ndig) begin
        if (ndig == 1) send_byte(8'("0" + $urandom_range(0, 5)));
        else send_byte(8'("0" + $urandom_range(0, 9)));
        len++;
      end
      if ($urandom_range(3) == 0) begin
        send_byte($urandom_range(3) == 0 ? 8'h00 : 8'($urandom_range(32, 126)));
        len++;
      end
    end
    if ($urandom_range(11) == 0) begin
      while (len <= LineLength) begin
        send_byte(8'($urandom_range(32, 255)));
        len++;
      end
    end else begin
      send_byte(8'h0D);
    end
  endtask

  // half random command lines, the rest buttons, expiries and raw noise
  task automatic random_phase(int unsigned target);
    int unsigned stop;
    stop = n_items + target;
    while (n_items < stop) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: random_line();
        5, 6: send_event(KIND_BUTTON, 3'($urandom_range(0, 7)));
        7: send_event(KIND_LOCK, 3'($urandom));
        8: send_event($urandom_range(3) == 0 ? KIND_AOFF : KIND_LOCK, 3'($urandom));
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    quiet = 1'b0;
    n_items = 0;
    stall_cnt = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults, IDN, TONE and FREQ OFF commands, button corner cases, both expiries
    send_line("*IDN?");
    send_line("TONE 2");
    send_line("FREQ OFF");
    send_event(KIND_BUTTON, 3'd1);
    send_event(KIND_BUTTON, 3'd1);
    send_event(KIND_BUTTON, 3'd0);
    send_event(KIND_BUTTON, 3'd7);
    send_event(KIND_LOCK, 3'd0);
    send_event(KIND_AOFF, 3'd0);
    drain();

    // extremes of both registers, upper data bits set on the step register
    write_reg(2'(REG_BASE), 16'hFFFF);
    write_reg(2'(REG_STEP), 16'hFFFF);
    write_reg(2'd2, 16'h1234);
    random_phase(90);
    drain();

    // smallest nonzero values: quotients collapse to zero or one
    write_reg(2'(REG_BASE), 16'd1);
    write_reg(2'(REG_STEP), 16'd1);
    random_phase(60);
    drain();

    // zero step: the zero-frequency path
    write_reg(2'(REG_STEP), 16'd0);
    write_reg(2'd3, 16'hFFFF);
    send_event(KIND_AOFF, 3'd0);
    send_event(KIND_BUTTON, 3'd4);
    send_line("TONE 3");
    drain();

    // back to the power-up values, with a stretch free of idling
    write_reg(2'(REG_BASE), 16'd36000);
    write_reg(2'(REG_STEP), 16'd1000);
    quiet = 1'b1;
    random_phase(80);
    quiet = 1'b0;
    random_phase(50);
    drain();

    // random register contents for the tail
    write_reg(2'(REG_BASE), 16'($urandom_range(1, 65535)));
    write_reg(2'(REG_STEP), 16'($urandom_range(1, 16383)));
    random_phase(100);
    drain();

    $display("covered %0d input beats, %0d result beats, %0d finished lines",
             n_items, sb.beats, sb.lines);
    $display("register sets: reset values, both extremes, zero step, random; %0d mismatches",
             sb.errors);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
